// ===== rtl/core/fsw_pkg.sv =====
package fsw_pkg;

   localparam int STORE_WORDS = 4096;
   localparam int MAX_TAPS    = 16;
   localparam int MAX_LINE    = 64;
   localparam int LBUF_WORDS  = MAX_LINE + 2 * MAX_TAPS;

   localparam int ADDR_W  = $clog2(STORE_WORDS);
   localparam int LBUF_AW = $clog2(LBUF_WORDS);
   localparam int TAP_AW  = $clog2(MAX_TAPS);

   localparam int IDX_W      = 12;
   localparam int VAL_W      = 18;
   localparam int COEF_W     = 32;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_LOW_TAP  = 2'd0,
      OP_HIGH_TAP = 2'd1,
      OP_SAMPLE   = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLS        = 3'd0,
      CSR_ROWS        = 3'd1,
      CSR_PLANES      = 3'd2,
      CSR_LEVELS      = 3'd3,
      CSR_LOW_TAPS    = 3'd4,
      CSR_LOW_CENTER  = 3'd5,
      CSR_HIGH_TAPS   = 3'd6,
      CSR_HIGH_CENTER = 3'd7
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_BASE,
      ST_CHK_LVL,
      ST_PASS,
      ST_LINE,
      ST_LOAD,
      ST_LDRAIN,
      ST_FILT,
      ST_FDRAIN,
      ST_FWR,
      ST_LEND,
      ST_DONE,
      ST_ERR
   } state_type;

endpackage

// ===== rtl/core/forward_symmetric_wavelet.sv =====
// Forward separable wavelet transform with symmetric extension. Tap loads, sample loads
// and coefficient reads are req transactions; a sample load with tlast set starts the
// transform and answers one done or error status on rsp. A read is answered from the
// sample store's registered read port. The transform is run by one multiply-accumulate
// unit: each line is first copied, extended by left and right samples, out of the store
// into a line buffer, then each output coefficient is accumulated over its taps, and the
// block accepts no req transaction until it is done. A plan check comes first. Samples
// are stored in Q24.8, taps are Q2.16, outputs are rounded to nearest and saturated to
// 32 bits.
module forward_symmetric_wavelet (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fsw_pkg::REQ_DATA_W-1:0]   req_tdata,   // index, value, zero pad
   input  logic [fsw_pkg::OP_W-1:0]         req_tuser,   // operation
   input  logic                             req_tlast,   // last_sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fsw_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // coefficient
   output logic [fsw_pkg::KIND_W-1:0]       rsp_tuser,   // result_kind
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fsw_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fsw_pkg::*;

   function automatic logic line_fits(input logic [6:0] len, input logic [3:0] l,
                                      input logic [3:0] r, input logic odd);
      logic [7:0] lx;
      logic [7:0] rx;
      logic [7:0] nx;
      lx = {4'b0, l};
      rx = {4'b0, r};
      nx = {1'b0, len};
      if (odd) begin
         return (nx >= 8'd1) && (lx + 8'd1 <= nx) && (rx + 8'd1 <= nx);
      end
      return (lx <= nx) && (rx <= nx);
   endfunction

   function automatic logic [6:0] halve(input logic [6:0] x);
      logic [7:0] s;
      s = ({1'b0, x} + 8'd1) >> 1;
      return s[6:0];
   endfunction

   // configuration
   logic [6:0] col_ff, col_in, row_ff, row_in, pln_ff, pln_in;
   logic [2:0] lvl_ff, lvl_in;
   logic [4:0] ltaps_ff, ltaps_in, htaps_ff, htaps_in;
   logic [3:0] lctr_ff, lctr_in, hctr_ff, hctr_in;

   // sequencer
   state_type state_ff, state_in;
   logic [3:0]  left_ff, left_in, right_ff, right_in;
   logic [6:0]  csz_ff, csz_in, rsz_ff, rsz_in, psz_ff, psz_in;
   logic [2:0]  lv_ff, lv_in;
   logic [11:0] rc_ff, rc_in;
   logic [1:0]  pass_ff, pass_in;
   logic [6:0]  len_ff, len_in, acnt_ff, acnt_in, bcnt_ff, bcnt_in, a_ff, a_in, b_ff, b_in;
   logic [11:0] stride_ff, stride_in, sa_ff, sa_in, sb_ff, sb_in;
   logic [11:0] abase_ff, abase_in, boff_ff, boff_in, base_ff, base_in;
   logic [6:0]  j_ff, j_in, o_ff, o_in, jd_ff, jd_in;
   logic [3:0]  t_ff, t_in;
   logic        ld_v_ff, ld_v_in, f1_ff, f1_in, f2_ff, f2_in;
   logic signed [17:0] tap_ff, tap_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [54:0] acc_ff, acc_in;

   // response
   logic        rsp_valid_ff, rsp_valid_in, rd_pend_ff, rd_pend_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic signed [17:0] low_tab_ff [MAX_TAPS];
   logic signed [17:0] high_tab_ff [MAX_TAPS];

   logic               req_fire;
   op_type             req_op;
   logic [IDX_W-1:0]   req_index;
   logic signed [17:0] req_value;
   logic [31:0]        sample_q;
   logic               tap_hit;

   logic               store_we;
   logic [ADDR_W-1:0]  store_waddr, store_raddr;
   logic [31:0]        store_wdata, store_rdata;
   logic [LBUF_AW-1:0] lbuf_raddr;
   logic [31:0]        lbuf_rdata;

   logic        odd_taps;
   logic [8:0]  jx, lx, ex, sx;
   logic [6:0]  src_idx, mul_idx;
   logic [18:0] mul_prod;
   logic [11:0] calc_addr;
   logic [7:0]  total;
   logic [6:0]  half, oo, pos;
   logic        is_high;
   logic [3:0]  ctr;
   logic [4:0]  ntap;
   logic [13:0] rc_full;
   logic [20:0] vol;
   logic [4:0]  ra, rb;
   logic        base_ok, dims_ok;
   logic signed [54:0] rnd_sum;
   logic signed [38:0] rnd_q;
   logic [31:0] coef_sat;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff && !rd_pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_index  = req_tdata[IDX_W-1:0];
   assign req_value  = $signed(req_tdata[IDX_W+VAL_W-1:IDX_W]);
   assign sample_q   = {{6{req_value[17]}}, req_value, 8'd0};
   assign tap_hit    = (req_index[IDX_W-1:TAP_AW] == '0);

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   fsw_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   fsw_ram #(.WIDTH(32), .DEPTH(LBUF_WORDS)) u_lbuf (
      .clock   (clock),
      .wr_en   (ld_v_ff),
      .wr_addr (jd_ff),
      .wr_data (store_rdata),
      .rd_addr (lbuf_raddr),
      .rd_data (lbuf_rdata)
   );

   // config register writes
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      pln_in   = pln_ff;
      lvl_in   = lvl_ff;
      ltaps_in = ltaps_ff;
      lctr_in  = lctr_ff;
      htaps_in = htaps_ff;
      hctr_in  = hctr_ff;
      if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_COLS:        col_in   = csr_data;
            CSR_ROWS:        row_in   = csr_data;
            CSR_PLANES:      pln_in   = csr_data;
            CSR_LEVELS:      lvl_in   = csr_data[2:0];
            CSR_LOW_TAPS:    ltaps_in = csr_data[4:0];
            CSR_LOW_CENTER:  lctr_in  = csr_data[3:0];
            CSR_HIGH_TAPS:   htaps_in = csr_data[4:0];
            CSR_HIGH_CENTER: hctr_in  = csr_data[3:0];
         endcase
      end
   end

   // shared arithmetic
   always_comb begin
      odd_taps = ltaps_ff[0];
      jx = {2'b0, j_ff};
      lx = {2'b0, len_ff};
      ex = {5'b0, left_ff};
      if (jx < ex) begin
         sx = odd_taps ? ex - jx : ex - jx - 9'd1;
      end else if (jx < ex + lx) begin
         sx = jx - ex;
      end else begin
         sx = odd_taps ? (lx << 1) + ex - jx - 9'd2 : (lx << 1) + ex - jx - 9'd1;
      end
      src_idx   = sx[6:0];
      mul_idx   = (state_ff == ST_FWR) ? o_ff : src_idx;
      mul_prod  = {12'b0, mul_idx} * {7'b0, stride_ff};
      calc_addr = base_ff + mul_prod[11:0];
      total     = {4'b0, left_ff} + {1'b0, len_ff} + {4'b0, right_ff};

      half    = halve(len_ff);
      is_high = (o_ff >= half);
      oo      = is_high ? o_ff - half : o_ff;
      ctr     = is_high ? hctr_ff : lctr_ff;
      ntap    = is_high ? htaps_ff : ltaps_ff;
      pos     = {3'b0, left_ff} - {3'b0, ctr} + {oo[5:0], 1'b0};
      lbuf_raddr = pos + {3'b0, t_ff};

      rnd_sum = acc_ff + 55'sd32768;
      rnd_q   = rnd_sum[54:16];
      if (rnd_q > 39'sd2147483647) begin
         coef_sat = 32'h7fff_ffff;
      end else if (rnd_q < -39'sd2147483648) begin
         coef_sat = 32'h8000_0000;
      end else begin
         coef_sat = rnd_q[31:0];
      end

      rc_full = {7'b0, col_ff} * {7'b0, row_ff};
      vol     = {7'b0, rc_full} * {14'b0, pln_ff};
      ra      = ltaps_ff - {1'b0, lctr_ff} - 5'd1;
      rb      = htaps_ff - {1'b0, hctr_ff} - 5'd1;
      base_ok = (col_ff != 0) && (row_ff != 0) && (pln_ff != 0)
             && (col_ff <= 7'(MAX_LINE)) && (row_ff <= 7'(MAX_LINE))
             && (pln_ff <= 7'(MAX_LINE)) && (vol <= 21'(STORE_WORDS))
             && (ltaps_ff != 0) && (ltaps_ff <= 5'(MAX_TAPS))
             && (htaps_ff != 0) && (htaps_ff <= 5'(MAX_TAPS))
             && ({1'b0, lctr_ff} < ltaps_ff) && ({1'b0, hctr_ff} < htaps_ff);
      dims_ok = ((col_ff <= 7'd1) || line_fits(csz_ff, left_ff, right_ff, odd_taps))
             && ((row_ff <= 7'd1) || line_fits(rsz_ff, left_ff, right_ff, odd_taps))
             && ((pln_ff <= 7'd1) || line_fits(psz_ff, left_ff, right_ff, odd_taps));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_SAMPLE && req_tlast) begin
               state_in = ST_CHK_BASE;
            end
         end
         ST_CHK_BASE: state_in = base_ok ? ST_CHK_LVL : ST_ERR;
         ST_CHK_LVL: begin
            if (lv_ff == lvl_ff) begin
               state_in = ST_PASS;
            end else if (!dims_ok) begin
               state_in = ST_ERR;
            end
         end
         ST_PASS: begin
            priority if (pass_ff == 2'd3) begin
               state_in = ST_PASS;
            end else if (lv_ff == lvl_ff) begin
               state_in = ST_DONE;
            end else if ((pass_ff == 2'd0 && col_ff != 7'd1)
                      || (pass_ff == 2'd1 && row_ff != 7'd1)
                      || (pass_ff == 2'd2 && pln_ff != 7'd1)) begin
               state_in = ST_LINE;
            end
         end
         ST_LINE: state_in = ST_LOAD;
         ST_LOAD: begin
            if ({1'b0, j_ff} == total - 8'd1) begin
               state_in = ST_LDRAIN;
            end
         end
         ST_LDRAIN: state_in = ST_FILT;
         ST_FILT: begin
            if ({1'b0, t_ff} == ntap - 5'd1) begin
               state_in = ST_FDRAIN;
            end
         end
         ST_FDRAIN: begin
            if (!f1_ff && !f2_ff) begin
               state_in = ST_FWR;
            end
         end
         ST_FWR: state_in = (o_ff == len_ff - 7'd1) ? ST_LEND : ST_FILT;
         ST_LEND: begin
            if (b_ff == bcnt_ff - 7'd1 && a_ff == acnt_ff - 7'd1) begin
               state_in = ST_PASS;
            end else begin
               state_in = ST_LINE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         ST_ERR:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      csz_in    = csz_ff;
      rsz_in    = rsz_ff;
      psz_in    = psz_ff;
      lv_in     = lv_ff;
      rc_in     = rc_ff;
      pass_in   = pass_ff;
      len_in    = len_ff;
      stride_in = stride_ff;
      acnt_in   = acnt_ff;
      sa_in     = sa_ff;
      bcnt_in   = bcnt_ff;
      sb_in     = sb_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      abase_in  = abase_ff;
      boff_in   = boff_ff;
      base_in   = base_ff;
      j_in      = j_ff;
      o_in      = o_ff;
      t_in      = t_ff;
      jd_in     = j_ff;
      ld_v_in   = 1'b0;
      f1_in     = 1'b0;
      f2_in     = f1_ff;
      tap_in    = is_high ? high_tab_ff[t_ff] : low_tab_ff[t_ff];
      prod_in   = $signed(lbuf_rdata) * tap_ff;
      acc_in    = f2_ff ? acc_ff + {{5{prod_ff[49]}}, prod_ff} : acc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rd_pend_in   = 1'b0;

      store_we    = 1'b0;
      store_waddr = req_index;
      store_wdata = sample_q;
      store_raddr = (state_ff == ST_LOAD) ? calc_addr : req_index;

      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_READ;
         rsp_data_in  = store_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_pend_in = (req_op == OP_READ);
               store_we   = (req_op == OP_SAMPLE);
            end
         end
         ST_CHK_BASE: begin
            left_in  = (lctr_ff > hctr_ff) ? lctr_ff : hctr_ff;
            right_in = (ra > rb) ? ra[3:0] : rb[3:0];
            rc_in    = rc_full[11:0];
            csz_in   = col_ff;
            rsz_in   = row_ff;
            psz_in   = pln_ff;
            lv_in    = '0;
         end
         ST_CHK_LVL: begin
            if (lv_ff == lvl_ff) begin
               csz_in  = col_ff;
               rsz_in  = row_ff;
               psz_in  = pln_ff;
               lv_in   = '0;
               pass_in = '0;
            end else begin
               csz_in = halve(csz_ff);
               rsz_in = halve(rsz_ff);
               psz_in = halve(psz_ff);
               lv_in  = lv_ff + 3'd1;
            end
         end
         ST_PASS: begin
            a_in     = '0;
            b_in     = '0;
            abase_in = '0;
            boff_in  = '0;
            priority if (pass_ff == 2'd3) begin
               csz_in  = halve(csz_ff);
               rsz_in  = halve(rsz_ff);
               psz_in  = halve(psz_ff);
               lv_in   = lv_ff + 3'd1;
               pass_in = '0;
            end else if (lv_ff == lvl_ff) begin
               pass_in = pass_ff;
            end else if (pass_ff == 2'd0) begin
               pass_in   = 2'd1;
               len_in    = csz_ff;
               stride_in = 12'd1;
               acnt_in   = psz_ff;
               sa_in     = rc_ff;
               bcnt_in   = rsz_ff;
               sb_in     = {5'b0, col_ff};
            end else if (pass_ff == 2'd1) begin
               pass_in   = 2'd2;
               len_in    = rsz_ff;
               stride_in = {5'b0, col_ff};
               acnt_in   = psz_ff;
               sa_in     = rc_ff;
               bcnt_in   = csz_ff;
               sb_in     = 12'd1;
            end else begin
               pass_in   = 2'd3;
               len_in    = psz_ff;
               stride_in = rc_ff;
               acnt_in   = rsz_ff;
               sa_in     = {5'b0, col_ff};
               bcnt_in   = csz_ff;
               sb_in     = 12'd1;
            end
         end
         ST_LINE: begin
            base_in = abase_ff + boff_ff;
            j_in    = '0;
            acc_in  = '0;
         end
         ST_LOAD: begin
            ld_v_in = 1'b1;
            jd_in   = j_ff;
            j_in    = j_ff + 7'd1;
         end
         ST_LDRAIN: begin
            o_in = '0;
            t_in = '0;
         end
         ST_FILT: begin
            f1_in = 1'b1;
            t_in  = t_ff + 4'd1;
         end
         ST_FDRAIN: begin
            t_in = '0;
         end
         ST_FWR: begin
            store_we    = 1'b1;
            store_waddr = calc_addr;
            store_wdata = coef_sat;
            acc_in      = '0;
            t_in        = '0;
            o_in        = o_ff + 7'd1;
         end
         ST_LEND: begin
            if (b_ff == bcnt_ff - 7'd1) begin
               b_in     = '0;
               boff_in  = '0;
               a_in     = a_ff + 7'd1;
               abase_in = abase_ff + sa_ff;
            end else begin
               b_in    = b_ff + 7'd1;
               boff_in = boff_ff + sb_ff;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_DONE;
            rsp_data_in  = '0;
         end
         ST_ERR: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ERROR;
            rsp_data_in  = '0;
         end
         default: begin
            rd_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         ld_v_ff      <= 1'b0;
         f1_ff        <= 1'b0;
         f2_ff        <= 1'b0;
         col_ff       <= 7'd64;
         row_ff       <= 7'd1;
         pln_ff       <= 7'd1;
         lvl_ff       <= 3'd1;
         ltaps_ff     <= 5'd2;
         lctr_ff      <= 4'd0;
         htaps_ff     <= 5'd2;
         hctr_ff      <= 4'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         ld_v_ff      <= ld_v_in;
         f1_ff        <= f1_in;
         f2_ff        <= f2_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pln_ff       <= pln_in;
         lvl_ff       <= lvl_in;
         ltaps_ff     <= ltaps_in;
         lctr_ff      <= lctr_in;
         htaps_ff     <= htaps_in;
         hctr_ff      <= hctr_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      csz_ff      <= csz_in;
      rsz_ff      <= rsz_in;
      psz_ff      <= psz_in;
      lv_ff       <= lv_in;
      rc_ff       <= rc_in;
      pass_ff     <= pass_in;
      len_ff      <= len_in;
      stride_ff   <= stride_in;
      acnt_ff     <= acnt_in;
      sa_ff       <= sa_in;
      bcnt_ff     <= bcnt_in;
      sb_ff       <= sb_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      abase_ff    <= abase_in;
      boff_ff     <= boff_in;
      base_ff     <= base_in;
      j_ff        <= j_in;
      o_ff        <= o_in;
      t_ff        <= t_in;
      jd_ff       <= jd_in;
      tap_ff      <= tap_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   // tap tables
   always_ff @(posedge clock) begin
      if (req_fire && tap_hit && req_op == OP_LOW_TAP) begin
         low_tab_ff[req_index[TAP_AW-1:0]] <= req_value;
      end
      if (req_fire && tap_hit && req_op == OP_HIGH_TAP) begin
         high_tab_ff[req_index[TAP_AW-1:0]] <= req_value;
      end
   end

endmodule

// ===== rtl/core/fsw_ram.sv =====
module fsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/forward_symmetric_wavelet_tb.sv =====
module forward_symmetric_wavelet_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsw_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [31:0] coef;
   } coef_result_type;

   localparam int IDLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 700;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   forward_symmetric_wavelet u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   int          coef_store [STORE_WORDS];
   bit          written [STORE_WORDS];
   int          line_ext [LBUF_WORDS];
   int          low_tap [MAX_TAPS];
   int          high_tap [MAX_TAPS];
   int unsigned cols, rows, planes, levels, ltaps, lctr, htaps, hctr;

   coef_result_type pending_results [$];
   int          mismatches;
   int          items_sent;
   int          reads_seen, done_seen, error_seen;
   int          req_idle_pct, rsp_idle_pct;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit line_ok(int len, int lt, int lc, int ht, int hc);
      int l, r;
      l = (lc > hc) ? lc : hc;
      r = ((lt - lc - 1) > (ht - hc - 1)) ? (lt - lc - 1) : (ht - hc - 1);
      if (lt % 2 == 1)
         return len >= 1 && l <= len - 1 && r <= len - 1;
      return l <= len && r <= len;
   endfunction

   function automatic bit plan_ok(int c, int r, int p, int lv, int lt, int lc, int ht, int hc);
      int cc, rr, pp;
      cc = c; rr = r; pp = p;
      if (c == 0 || r == 0 || p == 0) return 0;
      if (c > MAX_LINE || r > MAX_LINE || p > MAX_LINE) return 0;
      if (c * r * p > STORE_WORDS) return 0;
      if (lt == 0 || lt > MAX_TAPS || ht == 0 || ht > MAX_TAPS) return 0;
      if (lc >= lt || hc >= ht) return 0;
      for (int k = 0; k < lv; k++) begin
         if (c > 1 && !line_ok(cc, lt, lc, ht, hc)) return 0;
         if (r > 1 && !line_ok(rr, lt, lc, ht, hc)) return 0;
         if (p > 1 && !line_ok(pp, lt, lc, ht, hc)) return 0;
         cc = (cc + 1) / 2; rr = (rr + 1) / 2; pp = (pp + 1) / 2;
      end
      return 1;
   endfunction

   function automatic int mac_round(int pos, bit high);
      longint acc, q;
      int n;
      acc = 0;
      n = high ? htaps : ltaps;
      for (int j = 0; j < n; j++)
         if (pos + j < LBUF_WORDS)
            acc += longint'(line_ext[pos + j]) * longint'(high ? high_tap[j] : low_tap[j]);
      q = (acc + 32768) >>> 16;
      if (q > 64'sd2147483647) return 32'h7fffffff;
      if (q < -64'sd2147483648) return 32'h80000000;
      return int'(q);
   endfunction

   function automatic void filter_line(int base, int stride, int len);
      int v [MAX_LINE];
      int o [MAX_LINE];
      int l, r, j, half;
      l = (lctr > hctr) ? lctr : hctr;
      r = ((ltaps - lctr - 1) > (htaps - hctr - 1)) ? (ltaps - lctr - 1) : (htaps - hctr - 1);
      j = 0;
      for (int i = 0; i < len; i++) v[i] = coef_store[base + i * stride];
      if (ltaps % 2 == 1) begin
         for (int i = l; i > 0; i--) line_ext[j++] = v[i % MAX_LINE];
         for (int i = 0; i < len; i++) line_ext[j++] = v[i];
         for (int i = 0; i < r; i++) line_ext[j++] = v[(len - 2 - i) % MAX_LINE];
      end else begin
         for (int i = l; i > 0; i--) line_ext[j++] = v[(i - 1) % MAX_LINE];
         for (int i = 0; i < len; i++) line_ext[j++] = v[i];
         for (int i = 0; i < r; i++) line_ext[j++] = v[(len - 1 - i) % MAX_LINE];
      end
      half = (len + 1) / 2;
      for (int i = 0; i + 1 < len; i += 2) begin
         o[i / 2]        = mac_round(l - lctr + i, 1'b0);
         o[half + i / 2] = mac_round(l - hctr + i, 1'b1);
      end
      if (len % 2 == 1) o[len / 2] = mac_round(l - lctr + len - 1, 1'b0);
      for (int i = 0; i < len; i++) coef_store[base + i * stride] = o[i];
   endfunction

   function automatic void run_transform();
      int c, r, p;
      c = cols; r = rows; p = planes;
      for (int k = 0; k < levels; k++) begin
         if (cols > 1)
            for (int a = 0; a < p; a++)
               for (int b = 0; b < r; b++) filter_line((a * rows + b) * cols, 1, c);
         if (rows > 1)
            for (int a = 0; a < p; a++)
               for (int b = 0; b < c; b++) filter_line(a * rows * cols + b, cols, r);
         if (planes > 1)
            for (int a = 0; a < r; a++)
               for (int b = 0; b < c; b++) filter_line(a * cols + b, rows * cols, p);
         c = (c + 1) / 2; r = (r + 1) / 2; p = (p + 1) / 2;
      end
   endfunction

   function automatic void predict(op_type op, int idx, logic [17:0] val, bit last);
      int sv;
      coef_result_type e;
      sv = {{14{val[17]}}, val};
      case (op)
         OP_LOW_TAP:  if (idx < MAX_TAPS) low_tap[idx] = sv;
         OP_HIGH_TAP: if (idx < MAX_TAPS) high_tap[idx] = sv;
         OP_SAMPLE: begin
            coef_store[idx] = sv * 256;
            written[idx] = 1'b1;
            if (last) begin
               if (plan_ok(cols, rows, planes, levels, ltaps, lctr, htaps, hctr)) begin
                  run_transform();
                  e.kind = KIND_DONE;
               end else begin
                  e.kind = KIND_ERROR;
               end
               e.coef = '0;
               pending_results.push_back(e);
            end
         end
         default: begin
            e.kind = KIND_READ;
            e.coef = coef_store[idx];
            pending_results.push_back(e);
         end
      endcase
   endfunction

   task automatic send(op_type op, int idx, logic [17:0] val, bit last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, val, idx[11:0]};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict(op, idx, val, last);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(csr_type r, int v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data  <= v[6:0];
      do @(posedge clock); while (!csr_ready);
      case (r)
         CSR_COLS:        cols   = v & 127;
         CSR_ROWS:        rows   = v & 127;
         CSR_PLANES:      planes = v & 127;
         CSR_LEVELS:      levels = v & 7;
         CSR_LOW_TAPS:    ltaps  = v & 31;
         CSR_LOW_CENTER:  lctr   = v & 15;
         CSR_HIGH_TAPS:   htaps  = v & 31;
         CSR_HIGH_CENTER: hctr   = v & 15;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_plan(int c, int r, int p, int lv, int lt, int lc, int ht, int hc);
      wait_idle();
      csr_write(CSR_COLS, c);
      csr_write(CSR_ROWS, r);
      csr_write(CSR_PLANES, p);
      csr_write(CSR_LEVELS, lv);
      csr_write(CSR_LOW_TAPS, lt);
      csr_write(CSR_LOW_CENTER, lc);
      csr_write(CSR_HIGH_TAPS, ht);
      csr_write(CSR_HIGH_CENTER, hc);
   endtask

   function automatic logic [17:0] rand_value();
      if ($urandom_range(0, 1)) return 18'($urandom());
      return 18'($urandom_range(0, 1023) - 512);
   endfunction

   function automatic logic [17:0] rand_tap();
      if ($urandom_range(0, 3) == 0) return 18'($urandom());
      return 18'($urandom_range(0, 65536) - 32768);
   endfunction

   function automatic int pick_written();
      int k;
      do k = $urandom_range(0, STORE_WORDS - 1); while (!written[k]);
      return k;
   endfunction

   // taps, the whole array with tlast on the final sample, then reads and stray traffic
   task automatic run_frame(int c, int r, int p, int lv, int lt, int lc, int ht, int hc,
                            int n_reads, int n_stray);
      int n;
      n = c * r * p;
      set_plan(c, r, p, lv, lt, lc, ht, hc);
      for (int i = 0; i < lt && i < MAX_TAPS; i++) send(OP_LOW_TAP, i, rand_tap(), 1'b0);
      for (int i = 0; i < ht && i < MAX_TAPS; i++) send(OP_HIGH_TAP, i, rand_tap(), 1'b0);
      for (int i = 0; i < n; i++) send(OP_SAMPLE, i, rand_value(), i == n - 1);
      for (int i = 0; i < n_reads; i++)
         send(OP_READ, $urandom_range(0, n - 1), 18'($urandom()), 1'($urandom_range(0, 1)));
      for (int i = 0; i < n_stray; i++)
         case ($urandom_range(0, 2))
            0: send($urandom_range(0, 1) ? OP_LOW_TAP : OP_HIGH_TAP, $urandom_range(0, 4095),
                    rand_tap(), 1'($urandom_range(0, 1)));
            1: send(OP_SAMPLE, $urandom_range(n, STORE_WORDS - 1), rand_value(), 1'b0);
            default: send(OP_READ, pick_written(), 18'($urandom()),
                          1'($urandom_range(0, 1)));
         endcase
   endtask

   task automatic test_saturation();
      set_plan(4, 1, 1, 1, 2, 0, 2, 0);
      send(OP_LOW_TAP, 0, 18'h1ffff, 1'b0);
      send(OP_LOW_TAP, 1, 18'h20000, 1'b1);
      send(OP_HIGH_TAP, 0, 18'h20000, 1'b0);
      send(OP_HIGH_TAP, 1, 18'h1ffff, 1'b0);
      send(OP_HIGH_TAP, 4095, 18'h3ffff, 1'b1);
      send(OP_SAMPLE, 0, 18'h1ffff, 1'b0);
      send(OP_SAMPLE, 1, 18'h20000, 1'b0);
      send(OP_SAMPLE, 2, 18'h20000, 1'b0);
      send(OP_SAMPLE, 4095, 18'h2aaaa, 1'b0);
      send(OP_SAMPLE, 3, 18'h1ffff, 1'b1);
      for (int i = 0; i < 4; i++) send(OP_READ, i, 18'h3ffff, 1'b0);
      send(OP_READ, 4095, 18'h15555, 1'b1);
   endtask

   task automatic test_bad_plans();
      set_plan(0, 1, 1, 1, 2, 0, 2, 0);
      send(OP_SAMPLE, 0, 18'd5, 1'b1);
      set_plan(100, 1, 1, 1, 2, 0, 2, 0);
      send(OP_SAMPLE, 0, 18'd6, 1'b1);
      set_plan(64, 64, 2, 1, 2, 0, 2, 0);
      send(OP_SAMPLE, 0, 18'd7, 1'b1);
      set_plan(4, 1, 1, 1, 0, 0, 2, 0);
      send(OP_SAMPLE, 0, 18'd8, 1'b1);
      set_plan(4, 1, 1, 1, 2, 0, 17, 0);
      send(OP_SAMPLE, 0, 18'd9, 1'b1);
      set_plan(4, 1, 1, 1, 3, 3, 2, 0);
      send(OP_SAMPLE, 0, 18'd10, 1'b1);
      set_plan(3, 1, 1, 1, 6, 0, 2, 0);
      send(OP_SAMPLE, 0, 18'd11, 1'b1);
      set_plan(127, 127, 127, 7, 31, 15, 31, 15);
      send(OP_SAMPLE, 0, 18'd12, 1'b1);
      send(OP_READ, 0, 18'd0, 1'b0);
   endtask

   task automatic test_zero_levels();
      run_frame(5, 2, 1, 0, 2, 0, 2, 0, 4, 0);
   endtask

   task automatic test_extreme_shapes();
      run_frame(64, 1, 1, 6, 2, 0, 2, 0, 6, 0);
      run_frame(2, 64, 1, 1, 1, 0, 1, 0, 4, 0);
      run_frame(2, 1, 64, 6, 2, 1, 2, 0, 4, 0);
      run_frame(16, 1, 1, 1, 16, 15, 16, 0, 4, 0);
      run_frame(6, 3, 2, 2, 3, 1, 5, 2, 4, 0);
   endtask

   task automatic test_random_frames();
      int c, r, p, lv, lt, lc, ht, hc, stop;
      stop = items_sent + RANDOM_ITEMS;
      while (items_sent < stop) begin
         if (items_sent > stop - RANDOM_ITEMS / 3) begin
            req_idle_pct = 0; rsp_idle_pct = 0;
         end else if (items_sent > stop - 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 52; rsp_idle_pct = 7;
         end
         do begin
            c  = $urandom_range(0, 7) == 0 ? $urandom_range(2, 64) : $urandom_range(2, 10);
            r  = $urandom_range(0, 2) == 0 ? 1 : $urandom_range(2, 6);
            p  = $urandom_range(0, 2) == 0 ? $urandom_range(2, 4) : 1;
            if (c * r * p > 96) begin r = 1; p = 1; end
            lv = $urandom_range(0, 6);
            lt = $urandom_range(0, 5) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 5);
            ht = $urandom_range(0, 5) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 5);
            lc = $urandom_range(0, lt - 1);
            hc = $urandom_range(0, ht - 1);
         end while (!plan_ok(c, r, p, lv, lt, lc, ht, hc) && $urandom_range(0, 5) != 0);
         run_frame(c, r, p, lv, lt, lc, ht, hc, $urandom_range(3, 10), $urandom_range(0, 3));
      end
   endtask

   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 99) >= rsp_idle_pct);

   always @(posedge clock) begin
      coef_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         case (rsp_tuser)
            KIND_READ: reads_seen++;
            KIND_DONE: done_seen++;
            default:   error_seen++;
         endcase
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp transaction: kind %0d coef %h", rsp_tuser, rsp_tdata);
         end else begin
            e = pending_results.pop_front();
            if (rsp_tuser !== e.kind || rsp_tdata !== e.coef) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: expected kind %0d coef %h, got kind %0d coef %h",
                           e.kind, e.coef, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0; req_tlast = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      rsp_tready = 1'b0;
      idle_cycles = 0;
      req_idle_pct = 7; rsp_idle_pct = 52;
      cols = 64; rows = 1; planes = 1; levels = 1;
      ltaps = 2; lctr = 0; htaps = 2; hctr = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_saturation();
      test_bad_plans();
      test_zero_levels();
      test_extreme_shapes();
      test_random_frames();
      wait_idle();
      repeat (20) @(posedge clock);

      $display("sent %0d req transactions; checked %0d reads, %0d done, %0d error statuses",
               items_sent, reads_seen, done_seen, error_seen);
      $display("1D/2D/3D shapes, 0-6 levels, odd and even filters, saturation, bad plans");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== forward_symmetric_wavelet.f =====
rtl/core/fsw_pkg.sv
rtl/core/fsw_ram.sv
rtl/core/forward_symmetric_wavelet.sv
tb/forward_symmetric_wavelet_tb.sv
